### rtl/mmn_pkg.sv
// shared constants and types for the min-max byte normaliser
// no dependencies; imported by the top level, the quantiser and the testbench
`timescale 1ns / 1ps

package mmn_pkg;

  localparam int FRAME_SIZE  = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(FRAME_SIZE);
  localparam int COUNT_BITS  = $clog2(FRAME_SIZE + 1);
  localparam int LEVEL_BITS  = 8;
  localparam int TARGET_BITS = SAMPLE_BITS + LEVEL_BITS;

  // request kinds carried on tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic start;
    logic take;
  } quant_ctrl_t;

  typedef struct packed {
    logic done;
  } quant_stat_t;

endpackage

### rtl/min_max_normalize_to_byte_top.sv
// top level of the min-max byte normaliser: request handling, frame bookkeeping
// depends on mmn_pkg, mmn_ram and mmn_quant
`timescale 1ns / 1ps

// Loads a frame of up to 4096 unsigned 16-bit samples into an on-chip store while
// tracking the running minimum and maximum, then plays the frame back in load order
// with each sample scaled to a byte: the smallest k in 0..254 with
// 255*(v-min) <= k*(max-min), else 255; a flat frame gives 0. A load request
// (tuser = 0) produces no result; tlast on a load closes the frame. A read request
// (tuser = 1) on a complete frame returns one level, with tlast on the final
// sample; reads before the frame is closed or past its end are swallowed without
// a result. A read request occupies the block through the frame store read, the
// quantiser set-up, its bit-per-cycle search of k and the hand-over into the
// output register, which waits while the result channel stalls. A new load after
// a closed frame starts the next frame. Samples beyond 4096 are dropped.
// The store needs no clearing after reset, since only written entries are read.

module min_max_normalize_to_byte_top import mmn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  input  logic        s_axis_tuser,  // [0] func
  input  logic        s_axis_tlast,  // frame_end
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] level
  output logic        m_axis_tlast   // last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RAM   = 2'd1;
  localparam logic [1:0] ST_QUANT = 2'd2;

  logic [1:0]             state;
  logic [SAMPLE_BITS-1:0] running_min;
  logic [SAMPLE_BITS-1:0] running_max;
  logic [COUNT_BITS-1:0]  sample_count;
  logic [COUNT_BITS-1:0]  read_index;
  logic                   frame_ready;
  logic                   last_pending;
  logic                   out_valid;
  logic [LEVEL_BITS-1:0]  out_level;
  logic                   out_last;

  logic                   accept;
  logic                   load_req;
  logic                   read_req;
  logic                   read_ok;
  logic [COUNT_BITS-1:0]  eff_count;
  logic                   store_ok;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   out_free;
  quant_ctrl_t            q_ctrl;
  quant_stat_t            q_stat;
  logic [LEVEL_BITS-1:0]  q_level;

  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_req      = accept && (s_axis_tuser == FUNC_LOAD);
  assign read_req      = accept && (s_axis_tuser == FUNC_READ);

  // a read only counts on a closed frame with entries still to play back
  assign read_ok   = frame_ready && (read_index < sample_count);
  // a load after a closed frame restarts the count
  assign eff_count = frame_ready ? '0 : sample_count;
  assign store_ok  = (eff_count < COUNT_BITS'(FRAME_SIZE));
  assign out_free  = !out_valid || m_axis_tready;

  assign q_ctrl.start = (state == ST_RAM);
  assign q_ctrl.take  = (state == ST_QUANT) && q_stat.done && out_free;

  mmn_ram #(
    .DEPTH (FRAME_SIZE),
    .WIDTH (SAMPLE_BITS),
    .ADDR_W(ADDR_BITS)
  ) u_store (
    .clk  (clk),
    .we   (load_req && store_ok),
    .waddr(eff_count[ADDR_BITS-1:0]),
    .wdata(sample),
    .re   (read_req && read_ok),
    .raddr(read_index[ADDR_BITS-1:0]),
    .rdata(ram_rdata)
  );

  mmn_quant u_quant (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (q_ctrl),
    .value  (ram_rdata),
    .run_min(running_min),
    .run_max(running_max),
    .stat   (q_stat),
    .level  (q_level)
  );

  // request sequencing and frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_min  <= '0;
      running_max  <= '0;
      sample_count <= '0;
      read_index   <= '0;
      frame_ready  <= 1'b0;
      last_pending <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (load_req) begin
            if (frame_ready) begin
              frame_ready  <= 1'b0;
              sample_count <= '0;
              read_index   <= '0;
            end
            if (store_ok) begin
              sample_count <= eff_count + COUNT_BITS'(1);
              if (eff_count == '0) begin
                running_min <= sample;
                running_max <= sample;
              end else begin
                if (sample < running_min) begin
                  running_min <= sample;
                end
                if (sample > running_max) begin
                  running_max <= sample;
                end
              end
            end
            if (s_axis_tlast) begin
              frame_ready <= 1'b1;
              read_index  <= '0;
            end
          end else if (read_req && read_ok) begin
            last_pending <= (read_index + COUNT_BITS'(1) == sample_count);
            read_index   <= read_index + COUNT_BITS'(1);
            state        <= ST_RAM;
          end
        end
        ST_RAM: begin
          state <= ST_QUANT;
        end
        ST_QUANT: begin
          if (q_ctrl.take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register parts the quantiser from the result channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ctrl.take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ctrl.take) begin
      out_level <= q_level;
      out_last  <= last_pending;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_level;
  assign m_axis_tlast  = out_last;

endmodule

### rtl/mmn_ram.sv
// generic single-port-write, single-port-read synchronous ram
// registered read; no dependencies
`timescale 1ns / 1ps

module mmn_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mmn_quant.sv
// iterative quantiser: smallest k with k*range >= 255*(v-min), one bit per cycle
// depends on mmn_pkg
`timescale 1ns / 1ps

module mmn_quant import mmn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  quant_ctrl_t           ctrl,
  input  logic [SAMPLE_BITS-1:0] value,
  input  logic [SAMPLE_BITS-1:0] run_min,
  input  logic [SAMPLE_BITS-1:0] run_max,
  output quant_stat_t           stat,
  output logic [LEVEL_BITS-1:0] level
);

  localparam logic [1:0] Q_IDLE = 2'd0;
  localparam logic [1:0] Q_RUN  = 2'd1;
  localparam logic [1:0] Q_DONE = 2'd2;

  logic [1:0]             qstate;
  logic [TARGET_BITS-1:0] target;
  logic [TARGET_BITS:0]   acc;
  logic [TARGET_BITS-1:0] step_val;
  logic [LEVEL_BITS-1:0]  k;
  logic [LEVEL_BITS-1:0]  bitmask;
  logic                   d_zero;

  logic [SAMPLE_BITS-1:0] range;
  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS-1:0] d;
  logic [TARGET_BITS:0]   trial;

  always_comb begin
    range = run_max - run_min;
    diff  = value - run_min;
    if (value <= run_min) begin
      d = '0;
    end else if (diff > range) begin
      d = range;
    end else begin
      d = diff;
    end
    trial = acc + {1'b0, step_val};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qstate <= Q_IDLE;
    end else begin
      case (qstate)
        Q_IDLE: begin
          if (ctrl.start) begin
            qstate <= Q_RUN;
          end
        end
        Q_RUN: begin
          if (bitmask[0]) begin
            qstate <= Q_DONE;
          end
        end
        Q_DONE: begin
          if (ctrl.take) begin
            qstate <= Q_IDLE;
          end
        end
        default: qstate <= Q_IDLE;
      endcase
    end
  end

  // datapath: 255*d = (d << 8) - d, then trial sums of range << b
  always_ff @(posedge clk) begin
    if (qstate == Q_IDLE && ctrl.start) begin
      target   <= {d, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, d};
      acc      <= '0;
      step_val <= {1'b0, range, {(LEVEL_BITS-1){1'b0}}};
      k        <= '0;
      bitmask  <= {1'b1, {(LEVEL_BITS-1){1'b0}}};
      d_zero   <= (d == '0);
    end else if (qstate == Q_RUN) begin
      if (trial < {1'b0, target}) begin
        acc <= trial;
        k   <= k | bitmask;
      end
      step_val <= step_val >> 1;
      bitmask  <= bitmask >> 1;
    end
  end

  assign stat.done = (qstate == Q_DONE);
  assign level     = d_zero ? '0 : k + LEVEL_BITS'(1);

endmodule

### test/testbench.sv
// self-checking testbench for min_max_normalize_to_byte_top
// depends on mmn_pkg and the rtl of the block; reads no files
`timescale 1ns / 1ps

module testbench import mmn_pkg::*; ();

  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off to back the block up
  localparam int SETTLE_CYCLES = 40;    // quiet time after the last level arrives
  localparam int RANDOM_TARGET = 550;

  // one expected output level
  typedef struct packed {
    logic [7:0] level;
    logic       last;
  } level_out_t;

  // one request of the directed table; pinned rows carry a hand-written result
  typedef struct packed {
    logic        fn;
    logic [15:0] smp;
    logic        fe;
    logic        pinned;
    logic        has;
    logic [7:0]  lv;
    logic        lst;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = FUNC_LOAD;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  // shadow of the frame bookkeeping
  logic [15:0] frame_copy [0:FRAME_SIZE-1];
  logic [15:0] lo_seen = '0;
  logic [15:0] hi_seen = '0;
  int unsigned n_stored = 0;
  int unsigned next_out = 0;
  bit          closed = 1'b0;

  level_out_t  pending_levels [$];
  int          mismatches = 0;
  int          counted_requests = 0;
  int          quiet_cycles = 0;
  bit          paced = 1'b1;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  min_max_normalize_to_byte_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] sample
    .s_axis_tuser  (s_axis_tuser),   // [0] func
    .s_axis_tlast  (s_axis_tlast),   // frame_end
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] level
    .m_axis_tlast  (m_axis_tlast)    // last
  );

  always #2 clk = ~clk;

  // exact byte level: ceil(255*(v-min)/(max-min)), flat frame and v <= min give 0
  function automatic logic [7:0] scale_level(input logic [15:0] v);
    int unsigned span;
    int unsigned offset;
    int unsigned k;
    span = 32'(hi_seen) - 32'(lo_seen);
    if (span == 0 || v <= lo_seen) return 8'd0;
    offset = 32'(v) - 32'(lo_seen);
    if (offset > span) offset = span;
    k = (255 * offset + span - 1) / span;
    if (k > 255) k = 255;
    return k[7:0];
  endfunction

  // advance the shadow state by one accepted request and give its level, if any
  function automatic void track_request(input logic fn, input logic [15:0] smp,
                                        input logic fe, output bit has,
                                        output level_out_t res);
    has = 1'b0;
    res = '0;
    if (fn == FUNC_LOAD) begin
      // a load after a closed frame opens the next one
      if (closed) begin
        closed   = 1'b0;
        n_stored = 0;
        next_out = 0;
      end
      // samples past the store size are dropped and leave min and max alone
      if (n_stored < FRAME_SIZE) begin
        frame_copy[n_stored] = smp;
        if (n_stored == 0) begin
          lo_seen = smp;
          hi_seen = smp;
        end else begin
          if (smp < lo_seen) lo_seen = smp;
          if (smp > hi_seen) hi_seen = smp;
        end
        n_stored++;
      end
      // frame_end closes the frame even on a dropped sample
      if (fe) begin
        closed   = 1'b1;
        next_out = 0;
      end
    end else if (closed && next_out < n_stored) begin
      // reads on an open frame or past the end are swallowed
      has       = 1'b1;
      res.level = scale_level(frame_copy[next_out]);
      res.last  = (next_out + 1 == n_stored);
      next_out++;
    end
  endfunction

  // offer one request, after a random gap when paced, then book its expected level
  task automatic send_request(input plan_row_t row);
    int         gap;
    bit         has;
    level_out_t res;
    gap = paced ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.fn;
    s_axis_tdata  <= row.smp;
    s_axis_tlast  <= row.fe;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    track_request(row.fn, row.smp, row.fe, has, res);
    if (row.pinned) begin
      has       = row.has;
      res.level = row.lv;
      res.last  = row.lst;
    end
    if (has) pending_levels = {pending_levels, res};
    if (row.fn == FUNC_LOAD || has) counted_requests++;
  endtask

  task automatic flag_mismatch(input string what, input level_out_t want,
                               input logic [7:0] got_level, input logic got_last);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected level %0d last %0b, got level %0d last %0b",
               $realtime, what, want.level, want.last, got_level, got_last);
  endtask

  // result checker: every transfer on the result channel against the oldest expectation
  always @(posedge clk) begin
    level_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_levels.size() == 0) begin
        flag_mismatch("level with no request waiting", '0, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_levels.pop_front();
        if (m_axis_tdata !== want.level || m_axis_tlast !== want.last)
          flag_mismatch("wrong level", want, m_axis_tdata, m_axis_tlast);
      end
    end
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, steady stretches and one long hold-off on request
  initial begin
    int gap;
    int taken;
    bit steady;
    taken  = 0;
    steady = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (taken % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      taken++;
    end
  end

  // stimulus: directed table, one oversized frame, the hold-off frame, random frames
  initial begin
    plan_row_t   plan [25];
    plan_row_t   row;
    int          i;
    int          j;
    int          frame_len;
    int          reads_wanted;
    int unsigned span;
    int unsigned base;
    logic [15:0] smp;

    // a read on an empty or open frame gives nothing; min 0 / max 65535 frame;
    // flat frames; single-sample frame; a new load abandoning a readout
    plan = '{
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'h0000, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'hffff, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'h0001, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'hfffe, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'h8000, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b1, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b1, 8'd255, 1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'd777,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'd777,  1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b1, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b1, 8'd0,   1'b1},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'd40000, 1'b1, 1'b0, 1'b0, 8'd0,  1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b1, 8'd0,   1'b1},
      '{FUNC_LOAD, 16'd100,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'd200,  1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b1, 8'd0,   1'b0},
      '{FUNC_LOAD, 16'd300,  1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
      '{FUNC_READ, 16'h0000, 1'b0, 1'b1, 1'b1, 8'd0,   1'b1}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 25; i++) send_request(plan[i]);

    // oversized frame: the four loads past the store end carry 0 and 65535,
    // which must not move min or max; frame_end rides on a dropped sample
    paced = 1'b0;
    for (i = 0; i < FRAME_SIZE + 4; i++) begin
      row     = '0;
      row.fn  = FUNC_LOAD;
      row.smp = (i < FRAME_SIZE) ? 16'(1000 + $urandom_range(0, 1000))
                                 : ((i % 2 == 0) ? 16'h0000 : 16'hffff);
      row.fe  = (i == FRAME_SIZE + 3);
      send_request(row);
    end
    for (i = 0; i < 30; i++) begin
      row    = '0;
      row.fn = FUNC_READ;
      send_request(row);
    end

    counted_requests = 0;

    // back-to-back reads while the receiver holds off, so the block stalls its input
    for (i = 0; i < 20; i++) begin
      row     = '0;
      row.fn  = FUNC_LOAD;
      row.smp = 16'($urandom);
      row.fe  = (i == 19);
      send_request(row);
    end
    hold_off_req = 1'b1;
    for (i = 0; i < 21; i++) begin
      row     = '0;
      row.fn  = FUNC_READ;
      row.smp = 16'($urandom);
      send_request(row);
    end

    // random frames: mostly well formed, with stray reads, early frame ends,
    // short readouts and reads past the end mixed in
    while (counted_requests < RANDOM_TARGET) begin
      frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                              : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       span = 0;
        1:       span = $urandom_range(1, 3);
        2:       span = $urandom_range(4, 300);
        default: span = $urandom_range(301, 65535);
      endcase
      base  = $urandom_range(0, 65535 - span);
      paced = ($urandom_range(0, 3) != 0);
      for (i = 0; i < frame_len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          row     = '0;
          row.fn  = FUNC_READ;
          row.smp = 16'($urandom);
          row.fe  = 1'($urandom);
          send_request(row);
        end
        case ($urandom_range(0, 15))
          0:       smp = 16'(base);
          1:       smp = 16'(base + span);
          default: smp = 16'(base + $urandom_range(0, span));
        endcase
        row     = '0;
        row.fn  = FUNC_LOAD;
        row.smp = smp;
        row.fe  = (i == frame_len - 1) || ($urandom_range(0, 40) == 0);
        send_request(row);
      end
      case ($urandom_range(0, 5))
        0:       reads_wanted = $urandom_range(0, frame_len);
        1:       reads_wanted = frame_len + $urandom_range(1, 3);
        default: reads_wanted = frame_len;
      endcase
      for (j = 0; j < reads_wanted; j++) begin
        row     = '0;
        row.fn  = FUNC_READ;
        row.smp = 16'($urandom);
        row.fe  = 1'($urandom);
        send_request(row);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
